### design/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kinds, error codes, the word types passed between the scanner, the
// result queue and the output stage, and the keyword trie tables.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POS_W     = 24;
  localparam int VALUE_W   = 31;
  localparam int KIND_W    = 5;
  localparam int ERR_W     = 2;
  localparam int NODE_W    = 5;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // token kinds
  localparam logic [KIND_W-1:0] KIND_EOF    = 5'd0;
  localparam logic [KIND_W-1:0] KIND_STRING = 5'd1;
  localparam logic [KIND_W-1:0] KIND_INT    = 5'd2;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd3;
  localparam logic [KIND_W-1:0] KIND_DEF    = 5'd4;
  localparam logic [KIND_W-1:0] KIND_FUNC   = 5'd5;
  localparam logic [KIND_W-1:0] KIND_IF     = 5'd6;
  localparam logic [KIND_W-1:0] KIND_ELSE   = 5'd7;
  localparam logic [KIND_W-1:0] KIND_WHILE  = 5'd8;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd9;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd10;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd11;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd12;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd13;
  localparam logic [KIND_W-1:0] KIND_ARROW  = 5'd14;
  localparam logic [KIND_W-1:0] KIND_DOLLAR = 5'd15;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd16;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd17;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd18;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd19;
  localparam logic [KIND_W-1:0] KIND_STAR   = 5'd20;
  localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd21;
  localparam logic [KIND_W-1:0] KIND_LESS   = 5'd22;
  localparam logic [KIND_W-1:0] KIND_EQUAL  = 5'd23;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SYMBOL   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNTERM   = 2'd2;

  // keyword trie
  localparam logic [NODE_W-1:0] NODE_ROOT   = 5'd0;
  localparam logic [NODE_W-1:0] NODE_DEAD   = 5'd19;

  localparam logic [VALUE_W-1:0] VALUE_MAX  = {VALUE_W{1'b1}};

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   length;
    logic [ERR_W-1:0]   err;
  } stt_tok_t;

  // results of one input byte: slot 0 always used, slot 1 when two is set
  typedef struct packed {
    logic     two;
    stt_tok_t r0;
    stt_tok_t r1;
  } stt_rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // next trie node for def, func, if, else, while
  function automatic logic [NODE_W-1:0] trie_next(input logic [NODE_W-1:0] node,
                                                  input logic [7:0] c);
    logic [NODE_W-1:0] nxt;
    nxt = NODE_DEAD;
    case (node)
      5'd0: begin
        if (c == "d")      nxt = 5'd1;
        else if (c == "f") nxt = 5'd4;
        else if (c == "i") nxt = 5'd8;
        else if (c == "e") nxt = 5'd10;
        else if (c == "w") nxt = 5'd14;
      end
      5'd1:  if (c == "e") nxt = 5'd2;
      5'd2:  if (c == "f") nxt = 5'd3;
      5'd4:  if (c == "u") nxt = 5'd5;
      5'd5:  if (c == "n") nxt = 5'd6;
      5'd6:  if (c == "c") nxt = 5'd7;
      5'd8:  if (c == "f") nxt = 5'd9;
      5'd10: if (c == "l") nxt = 5'd11;
      5'd11: if (c == "s") nxt = 5'd12;
      5'd12: if (c == "e") nxt = 5'd13;
      5'd14: if (c == "h") nxt = 5'd15;
      5'd15: if (c == "i") nxt = 5'd16;
      5'd16: if (c == "l") nxt = 5'd17;
      5'd17: if (c == "e") nxt = 5'd18;
      default: nxt = NODE_DEAD;
    endcase
    return nxt;
  endfunction

  // keyword kind of a node, KIND_EOF when the node ends no keyword
  function automatic logic [KIND_W-1:0] keyword_kind(input logic [NODE_W-1:0] node);
    logic [KIND_W-1:0] k;
    case (node)
      5'd3:    k = KIND_DEF;
      5'd7:    k = KIND_FUNC;
      5'd9:    k = KIND_IF;
      5'd13:   k = KIND_ELSE;
      5'd18:   k = KIND_WHILE;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "$":     k = KIND_DOLLAR;
      ",":     k = KIND_COMMA;
      ";":     k = KIND_SEMI;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "=":     k = KIND_EQUAL;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

endpackage

### design/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front: byte scanner
// Accepts one byte word per cycle while q_full is low, advances the scan state
// and hands the results of that byte, packed as one record, to the result queue.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       char_code,
  input  logic             end_mark,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  logic             q_full,
  output logic             push,
  output stt_pkg::stt_rec_t rec
);
  import stt_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_COMMENT,
    M_SLASH, M_LESS, M_COLON, M_ERROR
  } mode_t;

  mode_t              mode, mode_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [POS_W-1:0]   tok_start, tok_start_next;
  logic [POS_W-1:0]   tok_size, tok_size_next;
  logic [VALUE_W-1:0] accum, accum_next;
  logic [NODE_W-1:0]  node, node_next;

  logic     accept;
  logic     a_vld, b_vld, do_start;
  stt_tok_t a_tok, b_tok, ident_tok;
  logic [VALUE_W+3:0] times_ten;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  // pending identifier or keyword
  always_comb begin
    ident_tok = '0;
    ident_tok.start = tok_start;
    if (keyword_kind(node) != KIND_EOF) begin
      ident_tok.kind = keyword_kind(node);
    end else begin
      ident_tok.kind   = KIND_IDENT;
      ident_tok.length = tok_size;
    end
  end

  assign times_ten = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0}
                   + {31'd0, char_code[3:0]};

  always_comb begin
    logic [KIND_W-1:0] pk;
    mode_next      = mode;
    pos_next       = pos;
    tok_start_next = tok_start;
    tok_size_next  = tok_size;
    accum_next     = accum;
    node_next      = node;
    a_vld          = 1'b0;
    b_vld          = 1'b0;
    a_tok          = '0;
    b_tok          = '0;
    do_start       = 1'b0;
    pk             = punct_kind(char_code);

    if (end_mark) begin
      unique case (mode)
        M_ERROR: ;
        M_STRING: begin
          a_vld = 1'b1; a_tok.start = tok_start; a_tok.err = ERR_UNTERM;
        end
        M_COLON: begin
          a_vld = 1'b1; a_tok.start = tok_start; a_tok.err = ERR_SYMBOL;
        end
        default: begin
          if (mode == M_NUMBER) begin
            a_vld = 1'b1; a_tok.kind = KIND_INT; a_tok.value = accum;
            a_tok.start = tok_start;
          end else if (mode == M_IDENT) begin
            a_vld = 1'b1; a_tok = ident_tok;
          end else if (mode == M_SLASH) begin
            a_vld = 1'b1; a_tok.kind = KIND_SLASH; a_tok.start = tok_start;
          end else if (mode == M_LESS) begin
            a_vld = 1'b1; a_tok.kind = KIND_LESS; a_tok.start = tok_start;
          end
          b_vld = 1'b1; b_tok.kind = KIND_EOF; b_tok.start = pos;
        end
      endcase
      mode_next      = M_IDLE;
      pos_next       = '0;
      tok_start_next = '0;
      tok_size_next  = '0;
      accum_next     = '0;
      node_next      = NODE_ROOT;
    end else begin
      unique case (mode)
        M_IDLE: do_start = 1'b1;
        M_COMMENT: if (char_code == 8'h0A) mode_next = M_IDLE;
        M_STRING: begin
          if (char_code == "\"") begin
            a_vld = 1'b1; a_tok.kind = KIND_STRING; a_tok.start = tok_start;
            a_tok.length = tok_size;
            mode_next = M_IDLE;
          end else if (tok_size != {POS_W{1'b1}}) begin
            tok_size_next = tok_size + 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(char_code)) begin
            accum_next = (times_ten > {4'd0, VALUE_MAX}) ? VALUE_MAX
                                                        : times_ten[VALUE_W-1:0];
          end else begin
            a_vld = 1'b1; a_tok.kind = KIND_INT; a_tok.value = accum;
            a_tok.start = tok_start;
            do_start = 1'b1;
          end
        end
        M_IDENT: begin
          if ((keyword_kind(node) != KIND_EOF) && !is_alpha(char_code)) begin
            a_vld = 1'b1; a_tok = ident_tok; do_start = 1'b1;
          end else if (is_alpha(char_code) || is_digit(char_code)) begin
            if (tok_size != {POS_W{1'b1}}) tok_size_next = tok_size + 1'b1;
            node_next = trie_next(node, char_code);
          end else begin
            a_vld = 1'b1; a_tok = ident_tok; do_start = 1'b1;
          end
        end
        M_SLASH: begin
          if (char_code == "/") begin
            mode_next = M_COMMENT;
          end else begin
            a_vld = 1'b1; a_tok.kind = KIND_SLASH; a_tok.start = tok_start;
            do_start = 1'b1;
          end
        end
        M_LESS: begin
          a_vld = 1'b1; a_tok.start = tok_start;
          if (char_code == "-") begin
            a_tok.kind = KIND_ARROW; mode_next = M_IDLE;
          end else begin
            a_tok.kind = KIND_LESS; do_start = 1'b1;
          end
        end
        M_COLON: begin
          a_vld = 1'b1; a_tok.start = tok_start;
          if (char_code == "=") begin
            a_tok.kind = KIND_ASSIGN; mode_next = M_IDLE;
          end else begin
            a_tok.err = ERR_SYMBOL; mode_next = M_ERROR;
          end
        end
        default: mode_next = M_ERROR;
      endcase
      pos_next = pos + 1'b1;

      // new token starts at this byte
      if (do_start) begin
        mode_next      = M_IDLE;
        tok_start_next = pos;
        tok_size_next  = '0;
        accum_next     = '0;
        node_next      = NODE_ROOT;
        priority if (char_code == "/") begin
          mode_next = M_SLASH;
        end else if (char_code == "\"") begin
          mode_next = M_STRING;
        end else if (is_digit(char_code)) begin
          mode_next  = M_NUMBER;
          accum_next = {27'd0, char_code[3:0]};
        end else if (is_alpha(char_code)) begin
          mode_next     = M_IDENT;
          tok_size_next = {{(POS_W-1){1'b0}}, 1'b1};
          node_next     = trie_next(NODE_ROOT, char_code);
        end else if (char_code == "<") begin
          mode_next = M_LESS;
        end else if (char_code == ":") begin
          mode_next = M_COLON;
        end else if (pk != KIND_EOF) begin
          b_vld = 1'b1; b_tok.kind = pk; b_tok.start = pos;
        end else if ((char_code == " ") || (char_code == 8'h0A) ||
                     (char_code == 8'h0D) || (char_code == 8'h09)) begin
          mode_next = M_IDLE;
        end else begin
          b_vld = 1'b1; b_tok.start = pos; b_tok.err = ERR_SYMBOL;
          mode_next = M_ERROR;
        end
      end
    end
  end

  // pack so that slot 0 always holds the first result
  always_comb begin
    rec.two = a_vld && b_vld;
    rec.r0  = a_vld ? a_tok : b_tok;
    rec.r1  = b_tok;
  end

  assign push = accept && (a_vld || b_vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      pos       <= '0;
      tok_start <= '0;
      tok_size  <= '0;
      accum     <= '0;
      node      <= NODE_ROOT;
    end else if (accept) begin
      mode      <= mode_next;
      pos       <= pos_next;
      tok_start <= tok_start_next;
      tok_size  <= tok_size_next;
      accum     <= accum_next;
      node      <= node_next;
    end
  end

endmodule

### design/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue: result record queue
// Short first-in first-out queue of per-byte result records between the
// scanner and the output stage.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stt_pkg::stt_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output stt_pkg::stt_rec_t head_rec
);
  import stt_pkg::*;

  stt_rec_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full     = (count == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count == '0);
  assign head_rec = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back: token output stage
// Takes records from the queue and sends their results one word per cycle
// while not stalled, through an output register, marking the last result of each byte.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           empty,
  input  stt_pkg::stt_rec_t              head_rec,
  output logic                           pop,
  output logic                           token_valid,
  input  logic                           token_stall,
  output logic [stt_pkg::KIND_W-1:0]     token_kind,
  output logic [stt_pkg::VALUE_W-1:0]    token_value,
  output logic [stt_pkg::POS_W-1:0]      start_offset,
  output logic [stt_pkg::POS_W-1:0]      token_length,
  output logic [stt_pkg::ERR_W-1:0]      error_code,
  output logic                           last_of_run
);
  import stt_pkg::*;

  logic     sel;
  logic     load, last;
  stt_tok_t cur;

  assign load = !empty && (!token_valid || !token_stall);
  assign cur  = sel ? head_rec.r1 : head_rec.r0;
  assign last = !head_rec.two || sel;
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      sel         <= 1'b0;
    end else if (load) begin
      token_valid <= 1'b1;
      sel         <= !last;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      token_kind   <= cur.kind;
      token_value  <= cur.value;
      start_offset <= cur.start;
      token_length <= cur.length;
      error_code   <= cur.err;
      last_of_run  <= last;
    end
  end

endmodule

### design/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexical tokenizer
// Turns a stream of source bytes, closed by an end word, into tokens:
// strings, integers, keywords, punctuation and identifiers, skipping comments.
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | role
//  --------+--------------------------------------------+---------------------
//  byte    | byte_valid, byte_stall, char_code,         | one source byte or
//          | end_mark                                   | end of text per word
//  token   | token_valid, token_stall, token_kind,      | one token or error
//          | token_value, start_offset, token_length,   | per word
//          | error_code, last_of_run                    |
//
//  A byte word is taken every cycle unless byte_stall is high; the scanner
//  settles it in that cycle. Each byte yields zero, one or two token words;
//  the output register sends one per cycle while token_stall is low.
//  A four-record queue sits between scanner and output register; byte_stall
//  rises only while that queue is full.
//  Synchronous reset clears the scan state, the queue and token_valid.
//
module source_text_tokenizer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  char_code,
  input  logic                        end_mark,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  output logic                        token_valid,
  input  logic                        token_stall,
  output logic [stt_pkg::KIND_W-1:0]  token_kind,
  output logic [stt_pkg::VALUE_W-1:0] token_value,
  output logic [stt_pkg::POS_W-1:0]   start_offset,
  output logic [stt_pkg::POS_W-1:0]   token_length,
  output logic [stt_pkg::ERR_W-1:0]   error_code,
  output logic                        last_of_run
);
  import stt_pkg::*;

  logic     push, pop, q_full, q_empty;
  stt_rec_t push_rec, head_rec;

  // scan one byte per cycle while the queue is not full, hand results to the queue
  stt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .end_mark   (end_mark),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .q_full     (q_full),
    .push       (push),
    .rec        (push_rec)
  );

  // decouple scanner from the token consumer
  stt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head_rec (head_rec)
  );

  // send results one token word per cycle while token_stall is low
  stt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .head_rec     (head_rec),
    .pop          (pop),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .token_value  (token_value),
    .start_offset (start_offset),
    .token_length (token_length),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

`ifndef SYNTHESIS
  // never write into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full) else $error("push into full result queue");

  // never read from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty) else $error("pop from empty result queue");

  // the second result of a byte follows right after the first
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (token_valid && !token_stall && !last_of_run) |=> token_valid)
    else $error("second result of a byte did not follow");
`endif

endmodule
